FILE: hdl/ume_pkg.sv
// shared types, constants and register codes for the distance conditioner
package ume_pkg;

   localparam int CHANNELS    = 6;
   localparam int CHAN_W      = 4;
   localparam int DIST_W      = 12;
   localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int STREAK_W    = 4;
   localparam int LIMIT_W     = 4;
   localparam int ALPHA_W     = 9;
   localparam int ALPHA_FULL  = 256;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 12;

   localparam logic [STREAK_W-1:0] STREAK_MAX = {STREAK_W{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIST   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_NAV    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TANK   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TANK_CHAN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_LIMIT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA      = 3'd5;

   // reset values
   localparam logic [DIST_W-1:0]  RST_MIN_DIST  = 12'd32;
   localparam logic [DIST_W-1:0]  RST_MAX_NAV   = 12'd3200;
   localparam logic [DIST_W-1:0]  RST_MAX_TANK  = 12'd1920;
   localparam logic [CHAN_W-1:0]  RST_TANK_CHAN = 4'd3;
   localparam logic [LIMIT_W-1:0] RST_INV_LIMIT = 4'd10;
   localparam logic [ALPHA_W-1:0] RST_ALPHA     = 9'd102;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [DIST_W-1:0] raw_dist;
      logic              raw_valid;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_channel;
      logic [DIST_W-1:0] filtered_dist;
      logic              filtered_valid;
      logic              reading_rejected;
   } rsp_type;

   typedef struct packed {
      logic [DIST_W-1:0]  min_valid_dist;
      logic [DIST_W-1:0]  max_nav_dist;
      logic [DIST_W-1:0]  max_tank_dist;
      logic [CHAN_W-1:0]  tank_channel_index;
      logic [LIMIT_W-1:0] invalid_limit;
      logic [ALPHA_W-1:0] alpha_q8;
   } cfg_type;

   typedef struct packed {
      logic              vld;
      logic [DIST_W-1:0] level;
   } hist_type;

   // classified reading handed from front to back
   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic              in_range;
      hist_type          cur;
      logic [DIST_W-1:0] hi_bound;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

FILE: hdl/ume_front.sv
// front stage: takes request beats, checks the channel and picks the upper bound
module ume_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ume_pkg::req_type  req_payload,
   input  ume_pkg::cfg_type  cfg,
   input  ume_pkg::qstat_type q_stat,
   output logic              push,
   output ume_pkg::item_type push_item
);

   logic               front_vld_ff, front_vld_in;
   ume_pkg::item_type  front_ff, front_in;
   logic               req_fire;

   assign req_stall = front_vld_ff & q_stat.full;
   assign req_fire  = req_valid & ~req_stall;
   assign push      = front_vld_ff & ~q_stat.full;
   assign push_item = front_ff;

   always_comb begin
      front_vld_in = req_fire | (front_vld_ff & ~push);
      front_in     = front_ff;
      if (req_fire) begin
         front_in.channel   = req_payload.channel;
         front_in.in_range  = {1'b0, req_payload.channel} <
                              (ume_pkg::CHAN_W+1)'(ume_pkg::CHANNELS);
         front_in.cur.vld   = req_payload.raw_valid;
         front_in.cur.level = req_payload.raw_valid ? req_payload.raw_dist
                                                    : '0;
         front_in.hi_bound  = (req_payload.channel == cfg.tank_channel_index)
                              ? cfg.max_tank_dist : cfg.max_nav_dist;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_vld_ff <= 1'b0;
      end else begin
         front_vld_ff <= front_vld_in;
      end
      front_ff <= front_in;
   end

endmodule

FILE: hdl/ume_queue.sv
// short fifo of classified readings between front and back
module ume_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ume_pkg::item_type  push_item,
   input  logic               pop,
   output ume_pkg::item_type  pop_item,
   output ume_pkg::qstat_type q_stat
);

   ume_pkg::item_type             slot_ff [ume_pkg::QUEUE_DEPTH];
   logic [ume_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ume_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ume_pkg::QPTR_W:0]      count_ff, count_in;

   assign q_stat.full  = count_ff == (ume_pkg::QPTR_W+1)'(ume_pkg::QUEUE_DEPTH);
   assign q_stat.empty = count_ff == '0;
   assign pop_item     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: hdl/ume_back.sv
// back stage: per-channel median, range check, streak and blend, result register
module ume_back (
   input  logic               clock,
   input  logic               reset,
   input  ume_pkg::cfg_type   cfg,
   input  ume_pkg::qstat_type q_stat,
   input  ume_pkg::item_type  pop_item,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ume_pkg::rsp_type   rsp_payload
);

   ume_pkg::hist_type              newer_ff  [ume_pkg::CHANNELS];
   ume_pkg::hist_type              older_ff  [ume_pkg::CHANNELS];
   ume_pkg::hist_type              filt_ff   [ume_pkg::CHANNELS];
   logic [ume_pkg::STREAK_W-1:0]   streak_ff [ume_pkg::CHANNELS];

   logic                           rsp_valid_ff, rsp_valid_in;
   ume_pkg::rsp_type               rsp_ff, rsp_in;

   logic [ume_pkg::CH_IDX_W-1:0]   idx;
   ume_pkg::hist_type              cur, newer, older, filt, med, filt_new;
   logic [ume_pkg::STREAK_W-1:0]   streak, streak_new;
   logic [ume_pkg::DIST_W-1:0]     a, b, c, lo_ab, hi_ab, lo_hc;
   logic                           rejected, write_state;
   logic [ume_pkg::ALPHA_W-1:0]    alpha_sat;
   logic signed [ume_pkg::DIST_W:0]   diff;
   logic signed [ume_pkg::ALPHA_W:0]  alpha_s;
   logic signed [22:0]             prod;
   logic signed [23:0]             blend;

   assign pop         = ~q_stat.empty & (~rsp_valid_ff | ~rsp_stall);
   assign write_state = pop & pop_item.in_range;
   assign idx         = pop_item.channel[ume_pkg::CH_IDX_W-1:0];
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      cur    = pop_item.cur;
      newer  = newer_ff[idx];
      older  = older_ff[idx];
      filt   = filt_ff[idx];
      streak = streak_ff[idx];

      // validity-aware median of three
      a     = cur.level;
      b     = newer.level;
      c     = older.level;
      lo_ab = (a < b) ? a : b;
      hi_ab = (a > b) ? a : b;
      lo_hc = (hi_ab < c) ? hi_ab : c;
      med   = '0;
      if (cur.vld && newer.vld && older.vld) begin
         med.vld   = 1'b1;
         med.level = (lo_ab > lo_hc) ? lo_ab : lo_hc;
      end else if (cur.vld) begin
         med = cur;
      end else if (newer.vld) begin
         med = newer;
      end else if (older.vld) begin
         med = older;
      end

      rejected = ~med.vld || (med.level < cfg.min_valid_dist) ||
                 (med.level > pop_item.hi_bound);

      // blend as old + alpha * (new - old), rounded
      alpha_sat = (cfg.alpha_q8 > ume_pkg::ALPHA_W'(ume_pkg::ALPHA_FULL))
                  ? ume_pkg::ALPHA_W'(ume_pkg::ALPHA_FULL) : cfg.alpha_q8;
      alpha_s   = $signed({1'b0, alpha_sat});
      diff      = $signed({1'b0, med.level}) - $signed({1'b0, filt.level});
      prod      = alpha_s * diff;
      blend     = $signed({4'b0, filt.level, 8'b0}) + 24'(prod) + 24'sd128;

      streak_new = streak;
      filt_new   = filt;
      if (rejected) begin
         if (streak != ume_pkg::STREAK_MAX) begin
            streak_new = streak + 1'b1;
         end
         if (streak_new >= cfg.invalid_limit) begin
            filt_new = '0;
         end
      end else begin
         streak_new   = '0;
         filt_new.vld = 1'b1;
         if (!filt.vld) begin
            filt_new.level = med.level;
         end else begin
            filt_new.level = blend[ume_pkg::DIST_W+7:8];
         end
      end

      rsp_valid_in = pop | (rsp_valid_ff & rsp_stall);
      rsp_in       = rsp_ff;
      if (pop) begin
         rsp_in.out_channel = pop_item.channel;
         if (pop_item.in_range) begin
            rsp_in.filtered_dist    = filt_new.vld ? filt_new.level : '0;
            rsp_in.filtered_valid   = filt_new.vld;
            rsp_in.reading_rejected = rejected;
         end else begin
            rsp_in.filtered_dist    = '0;
            rsp_in.filtered_valid   = 1'b0;
            rsp_in.reading_rejected = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ume_pkg::CHANNELS; i++) begin
            newer_ff[i]  <= '0;
            older_ff[i]  <= '0;
            filt_ff[i]   <= '0;
            streak_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < ume_pkg::CHANNELS; i++) begin
            if (write_state && idx == ume_pkg::CH_IDX_W'(i)) begin
               older_ff[i]  <= newer;
               newer_ff[i]  <= cur;
               filt_ff[i]   <= filt_new;
               streak_ff[i] <= streak_new;
            end
         end
      end
      rsp_ff <= rsp_in;
   end

endmodule

FILE: hdl/ultrasonic_median_ema_filter.sv
// top level of the multi-channel distance conditioner
//
// req_ beats carry one probe reading (channel, raw_dist, raw_valid); each
// accepted beat gives exactly one rsp_ beat for the same channel, in order.
// rsp_ reports the filtered distance, its valid flag and whether the
// median of the reading and the two previous readings was rejected.
// csr_ writes one of six registers (bounds, tank channel, reject limit,
// blend weight); write only while no beat is in flight.
// the front register loads at the accept edge, then a queue slot, then the result
// register, which drives rsp_valid.
// throughput: one beat per cycle unless rsp_stall or a full queue holds it;
// each pop reads and writes back its channel's history, streak and filtered value.
// when rsp_stall is high the result register holds its beat; the
// four-entry queue and the front register keep absorbing readings, and
// req_stall rises only once both are full.
// synchronous reset clears all channel history, streaks and filtered
// values, empties the queue and loads the registers with their defaults.
module ultrasonic_median_ema_filter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ume_pkg::req_type                 req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ume_pkg::rsp_type                 rsp_payload,
   input  logic                             csr_write,
   input  logic [ume_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ume_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   ume_pkg::cfg_type   cfg_ff, cfg_in;
   ume_pkg::qstat_type q_stat;
   ume_pkg::item_type  push_item, pop_item;
   logic               push, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            ume_pkg::CSR_MIN_DIST:  cfg_in.min_valid_dist     = csr_wdata;
            ume_pkg::CSR_MAX_NAV:   cfg_in.max_nav_dist       = csr_wdata;
            ume_pkg::CSR_MAX_TANK:  cfg_in.max_tank_dist      = csr_wdata;
            ume_pkg::CSR_TANK_CHAN: cfg_in.tank_channel_index =
                                       csr_wdata[ume_pkg::CHAN_W-1:0];
            ume_pkg::CSR_INV_LIMIT: cfg_in.invalid_limit      =
                                       csr_wdata[ume_pkg::LIMIT_W-1:0];
            ume_pkg::CSR_ALPHA:     cfg_in.alpha_q8           =
                                       csr_wdata[ume_pkg::ALPHA_W-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_valid_dist     <= ume_pkg::RST_MIN_DIST;
         cfg_ff.max_nav_dist       <= ume_pkg::RST_MAX_NAV;
         cfg_ff.max_tank_dist      <= ume_pkg::RST_MAX_TANK;
         cfg_ff.tank_channel_index <= ume_pkg::RST_TANK_CHAN;
         cfg_ff.invalid_limit      <= ume_pkg::RST_INV_LIMIT;
         cfg_ff.alpha_q8           <= ume_pkg::RST_ALPHA;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ume_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .q_stat      (q_stat),
      .push        (push),
      .push_item   (push_item)
   );

   ume_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_stat    (q_stat)
   );

   ume_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_stat      (q_stat),
      .pop_item    (pop_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: hdl/ume_checker.sv
// port-level checks for the distance conditioner, bound to the top level
module ume_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ume_pkg::rsp_type rsp_payload
);

   // a stalled result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed under stall");

   // reset leaves no result pending
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // invalid filtered output reads as zero distance
   a_zero_when_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.filtered_valid |-> rsp_payload.filtered_dist == '0)
      else $error("nonzero distance on invalid output");

   // an accepted reading always leaves a valid filtered value
   a_accept_gives_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.reading_rejected |-> rsp_payload.filtered_valid)
      else $error("accepted reading without valid output");

   // unknown channels are rejected with nothing valid
   a_bad_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ({1'b0, rsp_payload.out_channel} >=
                    (ume_pkg::CHAN_W+1)'(ume_pkg::CHANNELS))
      |-> rsp_payload.reading_rejected && !rsp_payload.filtered_valid)
      else $error("out-of-range channel not rejected");

endmodule

bind ultrasonic_median_ema_filter ume_checker u_ume_checker (.*);
